FILE: rtl/fcs_pkg.sv
// Shared types, constants and helper functions for the FAST corner score pipeline.
// Used by every module of the block; depends on nothing else.

package fcs_pkg;

  localparam int RING_MAX = 16;
  localparam int PIX_W    = 8;
  localparam int DIFF_W   = PIX_W + 1;
  localparam int GROUPS   = 4;
  localparam int GROUP_SZ = RING_MAX / GROUPS;

  // Configuration register indexes
  localparam logic CFG_IDX_MODE  = 1'b0;
  localparam logic CFG_IDX_FLOOR = 1'b1;

  // Raw mode register codes
  localparam logic [1:0] MODE_RING12 = 2'd1;
  localparam logic [1:0] MODE_RING8  = 2'd2;

  typedef logic signed [DIFF_W-1:0] diff_t;

  typedef enum logic [1:0] {
    RING16,
    RING12,
    RING8
  } ring_mode_t;

  typedef struct packed {
    ring_mode_t        mode;
    logic [PIX_W-1:0]  floor_val;
  } cfg_t;

  // Unused mode code falls back to the 16-point ring.
  function automatic ring_mode_t decode_mode(input logic [1:0] code);
    ring_mode_t m;
    case (code)
      MODE_RING12: m = RING12;
      MODE_RING8:  m = RING8;
      default:     m = RING16;
    endcase
    return m;
  endfunction

  // Reduce a ring position below 32 modulo the ring size.
  function automatic logic [3:0] wrap(input logic [4:0] x, input ring_mode_t m);
    logic [4:0] r;
    case (m)
      RING12: begin
        if (x >= 5'd24) begin
          r = x - 5'd24;
        end else if (x >= 5'd12) begin
          r = x - 5'd12;
        end else begin
          r = x;
        end
      end
      RING8:   r = {2'b00, x[2:0]};
      default: r = {1'b0, x[3:0]};
    endcase
    return r[3:0];
  endfunction

  function automatic diff_t smin(input diff_t a, input diff_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic diff_t smax(input diff_t a, input diff_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

FILE: rtl/fcs_diff.sv
// Stage 1: centre minus ring pixel for every ring position, ring wrapped by mode.
// Depends on fcs_pkg.

module fcs_diff
  import fcs_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  cfg_t                         cfg_in,
  input  logic [PIX_W-1:0]             center_pixel,
  input  logic [63:0]                  ring_low,
  input  logic [63:0]                  ring_high,
  output logic                         out_valid,
  output cfg_t                         cfg_out,
  output diff_t [RING_MAX-1:0]         diff
);

  logic [127:0]               ring_all;
  diff_t [RING_MAX-1:0]       diff_next;

  assign ring_all = {ring_high, ring_low};

  // Positions past the ring size repeat the ring, so later windows need no masking.
  for (genvar s = 0; s < RING_MAX; s++) begin : g_tap
    logic [3:0]       idx;
    logic [PIX_W-1:0] pix;
    assign idx          = wrap(5'(s), cfg_in.mode);
    assign pix          = ring_all[{idx, 3'b000} +: PIX_W];
    assign diff_next[s] = diff_t'({1'b0, center_pixel}) - diff_t'({1'b0, pix});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cfg_out <= cfg_in;
      diff    <= diff_next;
    end
  end

endmodule

FILE: rtl/fcs_arc.sv
// Stages 2 to 4: doubling min/max windows, then the arc minimum and negated maximum
// for every start position. Depends on fcs_pkg.

module fcs_arc
  import fcs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  cfg_t                   cfg_in,
  input  diff_t [RING_MAX-1:0]   diff,
  output logic                   out_valid,
  output cfg_t                   cfg_out,
  output diff_t [RING_MAX-1:0]   bright,
  output diff_t [RING_MAX-1:0]   dark
);

  // stage 2
  logic                  v2;
  cfg_t                  cfg2;
  diff_t [RING_MAX-1:0]  d2, mn2, mx2;
  diff_t [RING_MAX-1:0]  mn2_next, mx2_next;
  // stage 3
  logic                  v3;
  cfg_t                  cfg3;
  diff_t [RING_MAX-1:0]  d3, mn2_3, mx2_3, mn4, mx4;
  diff_t [RING_MAX-1:0]  mn4_next, mx4_next;
  // stage 4 inputs
  diff_t [RING_MAX-1:0]  bright_next, dark_next;

  for (genvar s = 0; s < RING_MAX; s++) begin : g_win
    logic [3:0] i1, i2, i4, i6, i8;
    diff_t      amin, amax;

    assign i1 = wrap(5'(s + 1), cfg_in.mode);
    assign mn2_next[s] = smin(diff[s], diff[i1]);
    assign mx2_next[s] = smax(diff[s], diff[i1]);

    assign i2 = wrap(5'(s + 2), cfg2.mode);
    assign mn4_next[s] = smin(mn2[s], mn2[i2]);
    assign mx4_next[s] = smax(mx2[s], mx2[i2]);

    assign i4 = wrap(5'(s + 4), cfg3.mode);
    assign i6 = wrap(5'(s + 6), cfg3.mode);
    assign i8 = wrap(5'(s + 8), cfg3.mode);

    // Arc of nine, seven or five built from the four-wide window at s.
    always_comb begin
      case (cfg3.mode)
        RING12: begin
          amin = smin(smin(mn4[s], mn2_3[i4]), d3[i6]);
          amax = smax(smax(mx4[s], mx2_3[i4]), d3[i6]);
        end
        RING8: begin
          amin = smin(mn4[s], d3[i4]);
          amax = smax(mx4[s], d3[i4]);
        end
        default: begin
          amin = smin(smin(mn4[s], mn4[i4]), d3[i8]);
          amax = smax(smax(mx4[s], mx4[i4]), d3[i8]);
        end
      endcase
    end

    assign bright_next[s] = amin;
    assign dark_next[s]   = -amax;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v2        <= in_valid;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cfg2    <= cfg_in;
      d2      <= diff;
      mn2     <= mn2_next;
      mx2     <= mx2_next;
      cfg3    <= cfg2;
      d3      <= d2;
      mn2_3   <= mn2;
      mx2_3   <= mx2;
      mn4     <= mn4_next;
      mx4     <= mx4_next;
      cfg_out <= cfg3;
      bright  <= bright_next;
      dark    <= dark_next;
    end
  end

endmodule

FILE: rtl/fcs_reduce.sv
// Stages 5 and 6: registered max tree over all arc values, then the floor and the
// final minus one. Depends on fcs_pkg.

module fcs_reduce
  import fcs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  cfg_t                   cfg_in,
  input  diff_t [RING_MAX-1:0]   bright,
  input  diff_t [RING_MAX-1:0]   dark,
  output logic                   out_valid,
  output logic [DIFF_W-1:0]      corner_score
);

  logic                  v5;
  cfg_t                  cfg5;
  diff_t [GROUPS-1:0]    grp, grp_next;
  diff_t                 top4;
  diff_t                 best;
  logic [DIFF_W-1:0]     score_next;

  // Each group folds four bright and four dark values: three compare levels.
  for (genvar g = 0; g < GROUPS; g++) begin : g_grp
    diff_t [GROUP_SZ-1:0] pm;
    for (genvar k = 0; k < GROUP_SZ; k++) begin : g_pair
      assign pm[k] = smax(bright[g*GROUP_SZ + k], dark[g*GROUP_SZ + k]);
    end
    assign grp_next[g] = smax(smax(pm[0], pm[1]), smax(pm[2], pm[3]));
  end

  assign top4       = smax(smax(grp[0], grp[1]), smax(grp[2], grp[3]));
  assign best       = smax(top4, diff_t'({1'b0, cfg5.floor_val}));
  assign score_next = best - diff_t'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v5        <= in_valid;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cfg5         <= cfg_in;
      grp          <= grp_next;
      corner_score <= score_next;
    end
  end

endmodule

FILE: rtl/fast_corner_score.sv
// FAST corner score, 9-of-16 family: top level with config registers and stream ports.
// Depends on fcs_pkg, fcs_diff, fcs_arc and fcs_reduce.

// One candidate pixel enters per clock unless the output beat is held; the score passes
// the difference stage, two window-doubling stages, the arc stage and two max-tree stages.
// The whole pipeline advances together: when the output beat is held, every stage holds
// and s_axis_tready drops in the same cycle. pattern_mode picks a 16, 12 or 8 point ring
// (code 3 acts as 16); the score is never below score_floor minus one. Both registers
// are sampled with each input beat and should be written only while the pipeline is empty.

module fast_corner_score
  import fcs_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  // config write port
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [7:0]    cfg_data,
  // input stream
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [135:0]  s_axis_tdata,   // center_pixel[7:0], ring_low[71:8], ring_high[135:72]
  // output stream
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [15:0]   m_axis_tdata    // corner_score[8:0] (signed), zero pad [15:9]
);

  logic [1:0]            pattern_mode;
  logic [PIX_W-1:0]      score_floor;
  logic                  en;
  cfg_t                  cfg_in, cfg1, cfg4;
  logic                  v1, v4;
  diff_t [RING_MAX-1:0]  diff;
  diff_t [RING_MAX-1:0]  bright, dark;
  logic [DIFF_W-1:0]     corner_score;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_mode <= '0;
      score_floor  <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_IDX_MODE) begin
        pattern_mode <= cfg_data[1:0];
      end
      if (cfg_index == CFG_IDX_FLOOR) begin
        score_floor <= cfg_data;
      end
    end
  end

  // advance all stages unless the output beat is stuck
  assign en            = m_axis_tready || !m_axis_tvalid;
  assign s_axis_tready = en;

  assign cfg_in.mode      = decode_mode(pattern_mode);
  assign cfg_in.floor_val = score_floor;

  fcs_diff u_diff (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (s_axis_tvalid),
    .cfg_in       (cfg_in),
    .center_pixel (s_axis_tdata[7:0]),
    .ring_low     (s_axis_tdata[71:8]),
    .ring_high    (s_axis_tdata[135:72]),
    .out_valid    (v1),
    .cfg_out      (cfg1),
    .diff         (diff)
  );

  fcs_arc u_arc (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v1),
    .cfg_in    (cfg1),
    .diff      (diff),
    .out_valid (v4),
    .cfg_out   (cfg4),
    .bright    (bright),
    .dark      (dark)
  );

  fcs_reduce u_reduce (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .in_valid     (v4),
    .cfg_in       (cfg4),
    .bright       (bright),
    .dark         (dark),
    .out_valid    (m_axis_tvalid),
    .corner_score (corner_score)
  );

  assign m_axis_tdata = {7'b0, corner_score};

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while output beat is stalled");

  a_score_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (corner_score != 9'h0FF && corner_score[8:7] != 2'b10))
    else $error("corner score outside -1..254");

  a_score_floor: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && $past(en) && !$past(cfg_we, 6) && !$past(cfg_we, 5)
     && !$past(cfg_we, 4) && !$past(cfg_we, 3) && !$past(cfg_we, 2) && !$past(cfg_we)
     && $past(en, 2) && $past(en, 3) && $past(en, 4) && $past(en, 5) && $past(en, 6))
    |-> ($signed(corner_score) >= $signed({1'b0, score_floor}) - 10'sd1))
    else $error("corner score below floor minus one");

endmodule

FILE: verif/fcs_score_checker.sv
// Score checker for fast_corner_score: tracks the config writes, predicts the corner score of
// every accepted input beat and compares each output beat in order against that prediction.
// Depends on fcs_pkg for the register indexes, mode codes and the ring mode enum.

module fcs_score_checker
  import fcs_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [7:0]    cfg_data,
  input  logic          in_valid,
  input  logic          in_ready,
  input  logic [135:0]  in_data,   // center_pixel[7:0], ring_low[71:8], ring_high[135:72]
  input  logic          out_valid,
  input  logic          out_ready,
  input  logic [15:0]   out_data,  // corner_score[8:0] (signed), zero pad [15:9]
  output int            mismatches,
  output int            pending,
  output int            scored
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [1:0] mode_reg;
  logic [7:0] floor_reg;
  logic [8:0] due_scores[$];

  // Best arc contrast over the ring (or the floor), minus one, as 9-bit two's complement.
  function automatic logic [8:0] corner_score_of(input logic [7:0] center,
                                                 input logic [63:0] lo_bytes,
                                                 input logic [63:0] hi_bytes,
                                                 input logic [1:0] code,
                                                 input logic [7:0] floor_v);
    ring_mode_t ring;
    int n, span, best, arc_lo, arc_hi, d, s, j;
    int diffs[16];
    case (code)
      MODE_RING12: ring = RING12;
      MODE_RING8:  ring = RING8;
      default:     ring = RING16;
    endcase
    case (ring)
      RING12: begin
        n = 12;
        span = 7;
      end
      RING8: begin
        n = 8;
        span = 5;
      end
      default: begin
        n = 16;
        span = 9;
      end
    endcase
    for (j = 0; j < n; j++) begin
      diffs[j] = int'(center) - int'(j < 8 ? lo_bytes[8*j +: 8] : hi_bytes[8*(j-8) +: 8]);
    end
    best = int'(floor_v);
    for (s = 0; s < n; s++) begin
      arc_lo = 1000;
      arc_hi = -1000;
      for (j = 0; j < span; j++) begin
        d = diffs[(s + j) % n];
        if (d < arc_lo) arc_lo = d;
        if (d > arc_hi) arc_hi = d;
      end
      if (arc_lo > best) best = arc_lo;
      if (-arc_hi > best) best = -arc_hi;
    end
    return 9'(best - 1);
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("%0t ns: %s mismatch, got %0d want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    logic [8:0] want;
    if (rst) begin
      mode_reg = '0;
      floor_reg = '0;
      due_scores.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_IDX_MODE) begin
          mode_reg = cfg_data[1:0];
        end else begin
          floor_reg = cfg_data;
        end
      end
      if (in_valid && in_ready) begin
        due_scores.push_back(corner_score_of(in_data[7:0], in_data[71:8], in_data[135:72],
                                             mode_reg, floor_reg));
      end
      if (out_valid && out_ready) begin
        if (due_scores.size() == 0) begin
          flag_mismatch("unexpected beat", int'($signed(out_data[8:0])), 0);
        end else begin
          want = due_scores.pop_front();
          if (out_data[8:0] != want) begin
            flag_mismatch("corner_score", int'($signed(out_data[8:0])), int'($signed(want)));
          end
          if (out_data[15:9] != '0) begin
            flag_mismatch("tdata pad", int'(out_data[15:9]), 0);
          end
          scored++;
        end
      end
    end
    pending <= due_scores.size();
  end

endmodule

FILE: verif/fast_corner_score_tb.sv
// Testbench top for fast_corner_score: clock, reset, config writes, input and output traffic.
// Depends on fcs_pkg, the fast_corner_score RTL and fcs_score_checker.

module fast_corner_score_tb
  import fcs_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_RING16 = 2'd0;
  localparam logic [1:0] MODE_SPARE  = 2'd3;
  localparam int PIPE_LAT    = 6;
  localparam int HOLD_CYCLES = 150;
  localparam int LIMIT       = 400000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 105;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_we = 1'b0;
  logic          cfg_index = CFG_IDX_MODE;
  logic [7:0]    cfg_data = '0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [135:0]  s_axis_tdata = '0;   // center_pixel[7:0], ring_low[71:8], ring_high[135:72]
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b1;
  logic [15:0]   m_axis_tdata;        // corner_score[8:0] (signed), zero pad [15:9]

  int mismatches, pending, scored;
  int items_sent = 0;
  int settings_seen = 1;
  int cycle_count = 0;
  bit rx_hold_req = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  fast_corner_score dut (
    .clk,
    .rst,
    .cfg_we,
    .cfg_index,
    .cfg_data,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  fcs_score_checker score_watch (
    .clk,
    .rst,
    .cfg_we,
    .cfg_index,
    .cfg_data,
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_data    (s_axis_tdata),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata),
    .mismatches,
    .pending,
    .scored
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("timeout after %0d cycles, %0d scores still due", cycle_count, pending);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offer one beat and hold it until the block takes it.
  task automatic send_beat(input logic [7:0] center, input logic [63:0] lo_bytes,
                           input logic [63:0] hi_bytes);
    s_axis_tdata <= {hi_bytes, lo_bytes, center};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic idle(input int cycles);
    if (cycles > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Pause the sender until every predicted score has come back, then let the pipe settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  task automatic set_config(input logic [1:0] mode, input logic [7:0] floor_v);
    cfg_we <= 1'b1;
    cfg_index <= CFG_IDX_MODE;
    cfg_data <= {6'b0, mode};
    @(posedge clk);
    cfg_index <= CFG_IDX_FLOOR;
    cfg_data <= floor_v;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_seen++;
  endtask

  // Half corner-shaped rings: an arc near the detection length pushed bright or dark,
  // some near-flat rings, and the rest pure noise. Unused bytes always get noise.
  function automatic logic [135:0] random_beat(input logic [1:0] mode);
    logic [7:0] center;
    logic [135:0] beat;
    int n, span, start, len, kind, j, rel, v;
    bit bright;
    case (mode)
      MODE_RING12: begin
        n = 12;
        span = 7;
      end
      MODE_RING8: begin
        n = 8;
        span = 5;
      end
      default: begin
        n = 16;
        span = 9;
      end
    endcase
    center = 8'($urandom_range(0, 255));
    kind = $urandom_range(0, 9);
    start = $urandom_range(0, n - 1);
    len = span - 1 + int'($urandom_range(0, 2));
    bright = $urandom_range(0, 1);
    beat = '0;
    beat[7:0] = center;
    for (j = 0; j < 16; j++) begin
      v = $urandom_range(0, 255);
      if (j < n) begin
        rel = (j - start + n) % n;
        if (kind < 5 && rel < len) begin
          v = bright ? int'(center) - int'($urandom_range(1, 255))
                     : int'(center) + int'($urandom_range(1, 255));
        end else if (kind < 7) begin
          v = int'(center) + int'($urandom_range(0, 8)) - 4;
        end
      end
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      beat[8 + 8*j +: 8] = v[7:0];
    end
    return beat;
  endfunction

  initial begin : sink
    int tick;
    tick = 0;
    forever begin
      @(posedge clk);
      tick++;
      if (rx_hold_req) begin
        // long back-pressure so the pipe fills and the input stalls
        rx_hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        case ((tick / 200) % 4)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
          2:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready <= ((tick % 7) < 3);
        endcase
      end
    end
  end

  initial begin : source
    logic [1:0] phase_mode[PHASES];
    logic [7:0] phase_floor[PHASES];
    logic [135:0] beat;
    int p, sent, burst, gap;
    phase_mode  = '{MODE_RING16, MODE_RING12, MODE_RING8, MODE_SPARE,
                    MODE_RING16, MODE_RING12, MODE_RING8, MODE_RING16};
    phase_floor = '{8'd0, 8'd0, 8'd0, 8'd20, 8'($urandom_range(1, 60)), 8'd255,
                    8'($urandom_range(1, 80)), 8'($urandom_range(0, 255))};

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // registers at reset: 16-point ring, zero floor
    send_beat(8'h80, {8{8'h80}}, {8{8'h80}});                         // flat ring
    send_beat(8'hFF, 64'h0, 64'h0);
    send_beat(8'h00, {8{8'hFF}}, {8{8'hFF}});
    send_beat(8'hFF, 64'h0, 64'hFFFF_FFFF_FFFF_FF00);                 // arc of exactly 9
    send_beat(8'hFF, 64'h0, {8{8'hFF}});                              // arc of 8 only
    send_beat(8'h00, 64'h0000_00FF_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000); // arc across the wrap
    send_beat(8'h80, 64'hFF00_FF00_FF00_FF00, 64'hFF00_FF00_FF00_FF00);
    send_beat(8'hAA, {8{8'h55}}, {8{8'h55}});
    drain();
    set_config(MODE_RING12, 8'd0);
    // unused upper bytes of ring_high must not extend the arc
    send_beat(8'hFF, 64'hFF00_0000_0000_0000, 64'h0000_0000_FFFF_FFFF);
    send_beat(8'h00, 64'h0000_00FF_FFFF_FFFF, 64'hAAAA_AAAA_FFFF_0000);
    send_beat(8'hFF, 64'hFFFF_0000_0000_0000, 64'h0000_0000_FFFF_FFFF);
    drain();
    set_config(MODE_RING8, 8'd0);
    // ring_high ignored entirely
    send_beat(8'h00, 64'hFFFF_0000_00FF_FFFF, 64'h0123_4567_89AB_CDEF);
    send_beat(8'h00, 64'h0000_0000_FFFF_FFFF, {8{8'hFF}});
    drain();
    set_config(MODE_SPARE, 8'd0);
    // spare mode code acts as the 16-point ring
    send_beat(8'hFF, 64'h0, 64'hFFFF_FFFF_FFFF_FF00);
    send_beat(8'hFF, 64'h0, {8{8'hFF}});
    drain();
    set_config(MODE_RING16, 8'd255);
    send_beat(8'hFF, 64'h0, 64'h0);
    send_beat(8'h80, {8{8'h80}}, {8{8'h80}});
    drain();
    set_config(MODE_RING8, 8'd100);
    send_beat(8'd200, {8{8'd50}}, 64'h0);
    send_beat(8'd150, {8{8'd100}}, {8{8'hFF}});

    for (p = 0; p < PHASES; p++) begin
      drain();
      set_config(phase_mode[p], phase_floor[p]);
      if (p == 4) rx_hold_req = 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        burst = (p == 4 && sent == 0) ? 40 : $urandom_range(1, 24);
        for (int i = 0; i < burst && sent < PHASE_ITEMS; i++) begin
          beat = random_beat(phase_mode[p]);
          send_beat(beat[7:0], beat[71:8], beat[135:72]);
          sent++;
        end
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        idle(gap);
      end
    end

    drain();
    $display("Sent %0d candidate pixels over %0d register settings (16/12/8 rings, spare code).",
             items_sent, settings_seen);
    $display("Checked %0d corner scores, %0d mismatches.", scored, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
